### hdl/kpc_pkg.sv
// Shared types, constants and tables for the keypad press-to-character block.
`default_nettype none

package kpc_pkg;

    localparam int unsigned RING_DEPTH_DEF = 32;
    localparam int unsigned CMDQ_DEPTH     = 4;

    localparam int unsigned KEYS_W      = 9;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned BCNT_W      = 5;
    localparam int unsigned KEY_CODES_W = 64;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 16;

    localparam logic [IDX_W-1:0] KEY_VOL_UP   = 4'd5;
    localparam logic [IDX_W-1:0] KEY_VOL_DOWN = 4'd8;

    localparam logic [CHAR_W-1:0] CHAR_ESC     = 8'h1B;
    localparam logic [CHAR_W-1:0] CHAR_BRACKET = 8'h5B;  // '['
    localparam logic [CHAR_W-1:0] CHAR_UP      = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_DOWN    = 8'h42;  // 'B'

    // h p e s . + f c -
    localparam logic [CHAR_W-1:0] BUTTON_LETTER [0:KEYS_W-1] = '{
        8'h68, 8'h70, 8'h65, 8'h73, 8'h2E, 8'h2B, 8'h66, 8'h63, 8'h2D
    };

    typedef enum logic {
        OP_KEY_EVENT = 1'b0,
        OP_READ      = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              direct;
        logic [KEYS_W-1:0] fresh;
    } cmd_t;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] key_char;
        logic [BCNT_W-1:0] buffered_count;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

### hdl/kpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kpc_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 32,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/kpc_front.sv
// Front end: accepts input transfers, finds new presses, queues commands.
`default_nettype none

module kpc_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [kpc_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    input  wire logic                                 s_axis_tuser,
    input  wire logic                                 q_full_i,
    output logic                                      q_push_o,
    output kpc_pkg::cmd_t                             q_cmd_o
);

    logic [kpc_pkg::KEYS_W-1:0] prev_keys_reg;
    logic [kpc_pkg::KEYS_W-1:0] prev_keys_next;
    logic [kpc_pkg::KEYS_W-1:0] keys;
    kpc_pkg::op_t               op;

    assign keys          = s_axis_tdata[kpc_pkg::KEYS_W-1:0];
    assign op            = kpc_pkg::op_t'(s_axis_tuser);
    assign s_axis_tready = !q_full_i;
    assign q_push_o      = s_axis_tvalid && !q_full_i;

    assign q_cmd_o.op     = op;
    assign q_cmd_o.direct = s_axis_tdata[kpc_pkg::KEYS_W];
    assign q_cmd_o.fresh  = keys & ~prev_keys_reg;

    always_comb begin
        prev_keys_next = prev_keys_reg;
        if (q_push_o && op == kpc_pkg::OP_KEY_EVENT) begin
            prev_keys_next = keys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
        end else begin
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule

`default_nettype wire

### hdl/kpc_cmdq.sv
// Short command queue between front end and back end.
`default_nettype none

module kpc_cmdq #(
    parameter  int unsigned DEPTH = kpc_pkg::CMDQ_DEPTH,
    localparam int unsigned PW    = $clog2(DEPTH),
    localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_i,
    input  wire kpc_pkg::cmd_t cmd_i,
    input  wire logic          pop_i,
    output kpc_pkg::cmd_t      cmd_o,
    output logic               full_o,
    output logic               empty_o
);

    kpc_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full_o  = (cnt_reg == CW'(DEPTH));
    assign empty_o = (cnt_reg == '0);
    assign cmd_o   = entry_reg[rptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= cmd_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/kpc_back.sv
// Back end: scans new presses, runs the character ring, drives the output register.
`default_nettype none

module kpc_back #(
    parameter  int unsigned RING_DEPTH = kpc_pkg::RING_DEPTH_DEF,
    localparam int unsigned AW         = $clog2(RING_DEPTH)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [kpc_pkg::KEY_CODES_W-1:0]     key_codes_i,
    input  wire logic                                q_empty_i,
    input  wire kpc_pkg::cmd_t                       q_cmd_i,
    output logic                                     q_pop_o,
    output logic                                     m_valid_o,
    output kpc_pkg::res_t                            m_res_o,
    input  wire logic                                m_ready_i
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_RESULT
    } state_t;

    state_t                         state_reg, state_next;
    logic                           direct_reg, direct_next;
    logic [kpc_pkg::KEYS_W-1:0]     pend_reg, pend_next;
    logic [kpc_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [1:0]                     sub_reg, sub_next;
    logic [kpc_pkg::IDX_W-1:0]      n_reg, n_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic [AW-1:0]                  count_reg, count_next;
    kpc_pkg::res_t                  hold_reg, hold_next;
    logic                           m_valid_reg, m_valid_next;
    kpc_pkg::res_t                  m_res_reg, m_res_next;

    logic                           ram_we;
    logic [kpc_pkg::CHAR_W-1:0]     ram_wdata;
    logic [kpc_pkg::CHAR_W-1:0]     ram_rdata;

    logic                           out_free;
    logic [kpc_pkg::KEYS_W-1:0]     bit_sel;
    logic [kpc_pkg::KEYS_W-1:0]     pend_left;
    logic                           is_vol;
    logic [kpc_pkg::CHAR_W-1:0]     vol_char;
    logic [kpc_pkg::CHAR_W-1:0]     code_char;
    logic [kpc_pkg::IDX_W-1:0]      n_inc;
    logic [AW-1:0]                  count_dec;

    kpc_ram #(
        .WIDTH (kpc_pkg::CHAR_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign m_valid_o = m_valid_reg;
    assign m_res_o   = m_res_reg;

    assign out_free  = !m_valid_reg || m_ready_i;
    assign bit_sel   = kpc_pkg::KEYS_W'(1) << idx_reg;
    assign pend_left = pend_reg & ~bit_sel;
    assign is_vol    = (idx_reg == kpc_pkg::KEY_VOL_UP) || (idx_reg == kpc_pkg::KEY_VOL_DOWN);
    assign code_char = key_codes_i[{idx_reg[2:0], 3'b000} +: kpc_pkg::CHAR_W];
    assign n_inc     = n_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    always_comb begin
        case (sub_reg)
            2'd0:    vol_char = kpc_pkg::CHAR_ESC;
            2'd1:    vol_char = kpc_pkg::CHAR_BRACKET;
            default: vol_char = (idx_reg == kpc_pkg::KEY_VOL_UP) ? kpc_pkg::CHAR_UP
                                                                 : kpc_pkg::CHAR_DOWN;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        direct_next  = direct_reg;
        pend_next    = pend_reg;
        idx_next     = idx_reg;
        sub_next     = sub_reg;
        n_next       = n_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        q_pop_o      = 1'b0;
        ram_we       = 1'b0;
        ram_wdata    = is_vol ? vol_char : code_char;

        if (m_valid_reg && m_ready_i) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty_i) begin
                    q_pop_o     = 1'b1;
                    direct_next = q_cmd_i.direct;
                    pend_next   = q_cmd_i.fresh;
                    idx_next    = '0;
                    sub_next    = '0;
                    n_next      = '0;
                    if (q_cmd_i.op == kpc_pkg::OP_READ) begin
                        if (count_reg == '0) begin
                            hold_next  = '{char_valid: 1'b0, key_char: '0,
                                           buffered_count: '0, last: 1'b1};
                            state_next = ST_RESULT;
                        end else begin
                            state_next = ST_RD_WAIT;
                        end
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg == '0) begin
                    // no press left: direct mode only gets here with no press at all
                    hold_next = '{char_valid: 1'b0, key_char: '0,
                                  buffered_count: direct_reg ? '0
                                                             : kpc_pkg::BCNT_W'(count_reg),
                                  last: 1'b1};
                    state_next = ST_RESULT;
                end else if (!pend_reg[idx_reg]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (direct_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_res_next   = '{char_valid: 1'b1,
                                         key_char: kpc_pkg::BUTTON_LETTER[idx_reg],
                                         buffered_count: kpc_pkg::BCNT_W'(n_inc),
                                         last: (pend_left == '0)};
                        pend_next    = pend_left;
                        n_next       = n_inc;
                        idx_next     = idx_reg + 1'b1;
                        if (pend_left == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    // one ring push per cycle; dropped once the ring holds depth-1
                    if (count_reg < AW'(RING_DEPTH - 1)) begin
                        ram_we     = 1'b1;
                        tail_next  = (tail_reg == AW'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (!is_vol || sub_reg == 2'd2) begin
                        pend_next = pend_left;
                        idx_next  = idx_reg + 1'b1;
                        sub_next  = '0;
                    end else begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
            end
            ST_RD_WAIT: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                hold_next  = '{char_valid: 1'b1, key_char: ram_rdata,
                               buffered_count: kpc_pkg::BCNT_W'(count_dec), last: 1'b1};
                head_next  = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_dec;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = hold_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        direct_reg <= direct_next;
        pend_reg   <= pend_next;
        idx_reg    <= idx_next;
        sub_reg    <= sub_next;
        n_reg      <= n_next;
        hold_reg   <= hold_next;
        m_res_reg  <= m_res_next;
    end

endmodule

`default_nettype wire

### hdl/keypad_press_to_char_fifo_top.sv
// Keypad press-to-character block: top level with configuration register.
//
// Input channel (s_axis): one transfer is a keypad event (tuser = 0) carrying
// the 3x3 key map, or a read request (tuser = 1). Output channel (m_axis):
// result items; a keypad event in direct mode yields one result per new
// press, everything else exactly one. tlast marks the final result of an item.
// cfg_we/cfg_wdata load the eight key codes; write only while the block is idle.
//
// Timing: a command queue decouples input from the back end. A read of a
// non-empty ring goes through ST_RD_WAIT, ST_RD_DATA (registered RAM read)
// and ST_RESULT to the output register. A buffered event scans key indices
// up to the highest new press (a volume key writes ESC, '[' and 'A'/'B'),
// then passes through ST_RESULT. Direct mode gives one letter per scanned
// press cycle while the output register is free. The back end handles one
// item at a time; the front keeps accepting until the 4-entry queue is full.
//
// Reset (aresetn low, synchronous) clears the previous key map, the ring
// pointers and count, the queue and the key codes; no clearing pass is needed.
// When m_axis_tready is low the output register holds; new results wait.
`default_nettype none

module keypad_press_to_char_fifo_top #(
    parameter int unsigned RING_DEPTH = kpc_pkg::RING_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [8:0] pressed_keys, [9] direct_mode, [15:10] zero
    input  wire logic [kpc_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // [0] operation
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] key_char, [12:8] buffered_count, [15:13] zero
    output logic      [kpc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [0] char_valid
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [kpc_pkg::KEY_CODES_W-1:0]     cfg_wdata
);

    logic [kpc_pkg::KEY_CODES_W-1:0] key_codes_reg, key_codes_next;
    logic                            q_push, q_pop, q_full, q_empty;
    kpc_pkg::cmd_t                   q_in_cmd, q_out_cmd;
    kpc_pkg::res_t                   m_res;

    always_comb begin
        key_codes_next = key_codes_reg;
        if (cfg_we) begin
            key_codes_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_codes_reg <= '0;
        end else begin
            key_codes_reg <= key_codes_next;
        end
    end

    kpc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full_i      (q_full),
        .q_push_o      (q_push),
        .q_cmd_o       (q_in_cmd)
    );

    kpc_cmdq #(
        .DEPTH (kpc_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (q_push),
        .cmd_i   (q_in_cmd),
        .pop_i   (q_pop),
        .cmd_o   (q_out_cmd),
        .full_o  (q_full),
        .empty_o (q_empty)
    );

    kpc_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key_codes_i (key_codes_reg),
        .q_empty_i   (q_empty),
        .q_cmd_i     (q_out_cmd),
        .q_pop_o     (q_pop),
        .m_valid_o   (m_axis_tvalid),
        .m_res_o     (m_res),
        .m_ready_i   (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, m_res.buffered_count, m_res.key_char};
    assign m_axis_tuser = m_res.char_valid;
    assign m_axis_tlast = m_res.last;

    // Queue occupancy cannot be full and empty at once.
    a_q_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("command queue both full and empty");

    // A result without a character always carries a zero character code.
    a_empty_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("invalid result with nonzero character");

    // Only direct-mode letters come as non-final results, and those are valid.
    a_mid_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
        else $error("non-final result without a character");

    // The back end never pops an empty queue.
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire
